>>> design/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 31;
  localparam int KEY_CHARS_DEFAULT   = 8;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_MOD    = 6'b000100,
    S_ISSUE  = 6'b001000,
    S_PROBE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> design/linear_probe_hash_table_top.sv
// Open-addressing hash table, linear probing with tombstones.
// Input channel (in_valid/in_stall) carries func and key; output channel
// (out_valid/out_stall) returns one transaction per input: status and slot_index.
// One operation is in flight at a time. After acceptance the key is normalised
// and its byte sum reduced modulo TABLE_SLOTS: first a reciprocal multiply for
// the quotient estimate, then one subtract and correct step.
// The probe then streams one slot per cycle out of the tag and key memories
// (registered reads), reading the next slot while the current one is
// checked, and stops on a match, an empty slot or a full wrap; it visits 1 to
// TABLE_SLOTS + 1 slots. The result is registered when the operation leaves
// its final state, and only then is the next input taken, so a new operation
// is not accepted before the previous one has finished.
// Reset starts a clearing pass that writes every tag to empty, TABLE_SLOTS
// cycles, during which in_stall stays high. Key storage is not cleared.
// A stalled result is held in the output register; the next operation may run
// meanwhile, and waits in its final state until the output register is free,
// so no table write happens before its result can be delivered.
`default_nettype none

module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT,
  parameter int KEY_CHARS   = KEY_CHARS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic [63:0]         key,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        slot_index
);

  localparam int IW    = $clog2(TABLE_SLOTS);
  localparam int SW    = $clog2(KEY_CHARS * 255 + 1);
  localparam int CW    = SW + IW;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);
  // floor(2^SW / TABLE_SLOTS): the quotient estimate is low by at most one
  localparam logic [CW-1:0] RECIP     = CW'((1 << SW) / TABLE_SLOTS);
  localparam logic [CW-1:0] SLOTS_CW  = CW'(TABLE_SLOTS);

  // memories
  logic [1:0]  tag_mem [TABLE_SLOTS];
  logic [63:0] key_mem [TABLE_SLOTS];

  state_t state, state_next;

  logic [IW-1:0]    clr_idx;
  logic [1:0]       func_q;
  logic [63:0]      key_q;
  logic [CW-1:0]    rem_q;
  logic             step;
  logic [CW-1:0]    quot_q;
  logic [IW-1:0]    home_q;
  logic [IW-1:0]    p_q;
  logic             first_cycle;
  logic [IW-1:0]    first_idx;
  tag_t             first_tag;
  logic [IW-1:0]    stop_idx;
  logic             stop_match;
  logic [IW-1:0]    ins_idx;
  tag_t             ins_tag;

  logic [1:0]  tag_rd;
  logic [63:0] key_rd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] p_next;

  logic [63:0]   nkey;
  logic [SW-1:0] nsum;

  logic            in_take;
  logic            finish_go;
  logic [2*CW-1:0] prod;
  logic [CW-1:0]   quot_sl;
  logic [CW-1:0]   rem_diff;

  tag_t cur_tag;
  logic cur_match;
  logic probe_stop;

  logic                tag_we;
  logic [IW-1:0]       tag_waddr;
  tag_t                tag_wdata;
  logic                key_we;
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_slot;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign finish_go = (state == S_FINISH) && (!out_valid || !out_stall);

  // key normalisation: bytes count up to the first zero or KEY_CHARS
  always_comb begin
    logic       alive;
    logic [7:0] ch;
    alive = 1'b1;
    nkey  = '0;
    nsum  = '0;
    for (int i = 0; i < 8; i++) begin
      ch = key[8*i +: 8];
      if (i >= KEY_CHARS || ch == 8'd0) alive = 1'b0;
      if (alive) begin
        nkey[8*i +: 8] = ch;
        nsum           = nsum + SW'(ch);
      end
    end
  end

  assign prod     = rem_q * RECIP;
  assign quot_sl  = quot_q * SLOTS_CW;
  assign rem_diff = rem_q - quot_sl;

  assign p_next  = (p_q == LAST_SLOT) ? '0 : p_q + 1'b1;
  assign rd_addr = (state == S_ISSUE) ? home_q : p_next;

  assign cur_tag   = tag_t'(tag_rd);
  assign cur_match = (cur_tag == TAG_USED) && (key_rd == key_q);

  // stop on match or empty, or when the walk is back at home
  assign probe_stop = cur_match || (cur_tag == TAG_EMPTY) ||
                      (!first_cycle && p_q == home_q);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_idx == LAST_SLOT) state_next = S_IDLE;
      S_IDLE:   if (in_take) state_next = S_MOD;
      S_MOD:    if (!step) state_next = S_ISSUE;
      S_ISSUE:  state_next = S_PROBE;
      S_PROBE:  if (probe_stop) state_next = S_FINISH;
      S_FINISH: if (finish_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_q <= func;
      key_q  <= nkey;
      rem_q  <= CW'(nsum);
      step   <= 1'b1;
    end
    if (state == S_MOD) begin
      step <= 1'b0;
      if (step) quot_q <= CW'(prod >> SW);
      else home_q <= (rem_diff >= SLOTS_CW) ? IW'(rem_diff - SLOTS_CW) : IW'(rem_diff);
    end
    if (state == S_ISSUE) begin
      p_q         <= home_q;
      first_cycle <= 1'b1;
    end
    if (state == S_PROBE) begin
      first_cycle <= 1'b0;
      if (first_cycle) begin
        first_idx <= p_q;
        first_tag <= cur_tag;
      end else if (cur_tag == TAG_DELETED && first_tag != TAG_DELETED) begin
        first_idx <= p_q;
        first_tag <= TAG_DELETED;
      end
      if (probe_stop) begin
        stop_idx   <= p_q;
        stop_match <= cur_match;
        if (first_cycle ||
            (cur_tag == TAG_EMPTY && first_tag != TAG_DELETED)) begin
          ins_idx <= p_q;
          ins_tag <= cur_tag;
        end else begin
          ins_idx <= first_idx;
          ins_tag <= first_tag;
        end
      end else begin
        p_q <= p_next;
      end
    end
  end

  // result and write-back
  always_comb begin
    res_status = ST_MISSING;
    res_slot   = '0;
    tag_we     = 1'b0;
    tag_waddr  = ins_idx;
    tag_wdata  = TAG_USED;
    key_we     = 1'b0;
    case (func_q)
      FUNC_FIND: begin
        if (stop_match) begin
          res_status = ST_FOUND;
          res_slot   = stop_idx;
        end
      end
      FUNC_INSERT: begin
        if (stop_match) begin
          res_status = ST_PRESENT;
          res_slot   = stop_idx;
        end else if (ins_tag inside {TAG_EMPTY, TAG_DELETED}) begin
          res_status = ST_INSERTED;
          res_slot   = ins_idx;
          tag_we     = finish_go;
          key_we     = finish_go;
        end else begin
          res_status = ST_FULL;
        end
      end
      FUNC_DELETE: begin
        if (stop_match) begin
          res_status = ST_FOUND;
          res_slot   = stop_idx;
          tag_we     = finish_go;
          tag_waddr  = stop_idx;
          tag_wdata  = TAG_DELETED;
        end
      end
      default: begin
        res_status = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR)  tag_mem[clr_idx] <= TAG_EMPTY;
    else if (tag_we)       tag_mem[tag_waddr] <= tag_wdata;
    if (key_we) key_mem[ins_idx] <= key_q;
    tag_rd <= tag_mem[rd_addr];
    key_rd <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      status     <= res_status;
      slot_index <= SLOT_W'(res_slot);
    end
  end

  // checks
  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (p_q <= LAST_SLOT && home_q <= LAST_SLOT))
    else $error("probe index out of range");

  a_empty_ins_nomatch: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && ins_tag == TAG_EMPTY) |-> !stop_match)
    else $error("empty insertion point with a matching stop slot");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_MISSING || status == ST_FULL)) |-> (slot_index == '0))
    else $error("slot_index not zero for a miss");

  a_no_write_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> (!tag_we && !key_we))
    else $error("table written while result stalled");

  a_home_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && !step) |-> (rem_diff < (SLOTS_CW << 1)))
    else $error("remainder estimate off by more than one");

endmodule

`default_nettype wire
